/* design/pet_pkg.sv */
// Shared types, constants and defaults for the Prewitt edge threshold block.
package pet_pkg;

    localparam int P_MAX_WIDTH  = 1024;
    localparam int P_PIXEL_BITS = 8;

    localparam int PIXEL_FIELD_BITS = 8;
    localparam int ROW_BITS         = 12;
    localparam int COL_BITS         = 10;
    localparam int EDGE_BITS        = 8;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int THRESH_BITS     = 11;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 13;

    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [WIDTH_REG_BITS-1:0]  RST_IMAGE_WIDTH    = 11'd1024;
    localparam logic [HEIGHT_REG_BITS-1:0] RST_IMAGE_HEIGHT   = 13'd1024;
    localparam logic [THRESH_BITS-1:0]     RST_EDGE_THRESHOLD = 11'd128;

    localparam logic [EDGE_BITS-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_BITS-1:0] EDGE_OFF = 8'd0;

    localparam int MID_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [PIXEL_FIELD_BITS-1:0] pixel;
        logic                        start_of_frame;
    } t_req;

    typedef struct packed {
        logic [ROW_BITS-1:0] center_row;
        logic [COL_BITS-1:0] center_col;
        logic                last;
    } t_tag;

    typedef struct packed {
        logic [EDGE_BITS-1:0] edge_value;
        logic [ROW_BITS-1:0]  center_row;
        logic [COL_BITS-1:0]  center_col;
        logic                 last;
    } t_res;

endpackage

/* design/pet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pet_fifo.sv */
// Small register-based FIFO with valid/ready on both sides.
module pet_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_out_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_in_ready  = (r_count != CNTW'(DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rptr];
    assign do_push     = i_in_valid && o_in_ready;
    assign do_pop      = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/pet_front.sv */
// Front end: raster position tracking, line stores and the 3x3 window.
module pet_front import pet_pkg::*; #(
    parameter int MAX_WIDTH  = P_MAX_WIDTH,
    parameter int PIXEL_BITS = P_PIXEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  t_req                              i_req,
    output logic                              o_full,
    input  logic [WIDTH_REG_BITS-1:0]         i_image_width,
    input  logic [HEIGHT_REG_BITS-1:0]        i_image_height,
    output logic                              o_ent_valid,
    input  logic                              i_ent_ready,
    output logic [2:0][2:0][PIXEL_BITS-1:0]   o_ent_win,
    output t_tag                              o_ent_tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int PB = PIXEL_BITS;

    logic [WB-1:0]              w_eff;
    logic [HEIGHT_REG_BITS-1:0] h_eff;

    logic                       accept;
    logic                       s1_fire;
    logic [CW-1:0]              col_a;
    logic [HEIGHT_REG_BITS-1:0] row_t;
    logic [HEIGHT_REG_BITS-1:0] row_n;
    logic [ROW_BITS-1:0]        row_a;
    logic [CW-1:0]              n_col;
    logic [ROW_BITS-1:0]        n_row;
    logic                       emit_a;
    t_tag                       tag_a;

    logic [CW-1:0]              r_col;
    logic [ROW_BITS-1:0]        r_row;

    logic                       r_clearing;
    logic [CW-1:0]              r_clr_addr;

    logic                       r_s1_valid;
    logic                       r_s1_emit;
    logic [CW-1:0]              r_s1_col;
    logic [PB-1:0]              r_s1_px;
    t_tag                       r_s1_tag;

    logic                       r_fwd_valid;
    logic [2*PB-1:0]            r_fwd_data;

    logic                       ram_we;
    logic [CW-1:0]              ram_waddr;
    logic [2*PB-1:0]            ram_wdata;
    logic [2*PB-1:0]            ram_rdata;
    logic [2*PB-1:0]            line;
    logic [PB-1:0]              top;
    logic [PB-1:0]              mid;

    logic [2:0][2:0][PB-1:0]    r_win;

    // Clamp geometry to the supported range
    always_comb begin
        if (i_image_width < WIDTH_REG_BITS'(MIN_DIM)) begin
            w_eff = WB'(MIN_DIM);
        end else if (32'(i_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(i_image_width);
        end
        if (i_image_height < HEIGHT_REG_BITS'(MIN_DIM)) begin
            h_eff = HEIGHT_REG_BITS'(MIN_DIM);
        end else if (32'(i_image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_REG_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = i_image_height;
        end
    end

    assign s1_fire = r_s1_valid && (!r_s1_emit || i_ent_ready);
    assign o_full  = r_clearing || (r_s1_valid && !s1_fire);
    assign accept  = i_push && !o_full;

    // Position of this pixel, wrapping stale counts first, then the next position
    always_comb begin
        col_a = i_req.start_of_frame ? '0 : r_col;
        row_t = i_req.start_of_frame ? '0 : {1'b0, r_row};
        if (32'(col_a) >= 32'(w_eff)) begin
            col_a = '0;
            row_t = row_t + 1'b1;
        end
        if (row_t >= h_eff) begin
            row_t = '0;
        end
        row_a = ROW_BITS'(row_t);

        row_n = {1'b0, row_a} + 1'b1;
        if (row_n >= h_eff) begin
            row_n = '0;
        end
        if (32'(col_a) + 32'd1 >= 32'(w_eff)) begin
            n_col = '0;
            n_row = ROW_BITS'(row_n);
        end else begin
            n_col = col_a + 1'b1;
            n_row = row_a;
        end

        emit_a           = (row_a >= ROW_BITS'(2)) && (col_a >= CW'(2));
        tag_a.center_row = row_a - 1'b1;
        tag_a.center_col = COL_BITS'(32'(col_a) - 32'd1);
        tag_a.last       = (32'(row_a) == 32'(h_eff) - 32'd1) &&
                           (32'(col_a) == 32'(w_eff) - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Sweep the line stores to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= emit_a;
            r_s1_col  <= col_a;
            r_s1_px   <= PB'(i_req.pixel);
            r_s1_tag  <= tag_a;
        end
    end

    // Bypass the column being written while the same column is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (accept) begin
            r_fwd_valid <= s1_fire && (r_s1_col == col_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= {mid, r_s1_px};
        end
    end

    assign line = r_fwd_valid ? r_fwd_data : ram_rdata;
    assign top  = line[2*PB-1:PB];
    assign mid  = line[PB-1:0];

    assign ram_we    = r_clearing || s1_fire;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s1_col;
    assign ram_wdata = r_clearing ? '0 : {mid, r_s1_px};

    // Older line in the upper half, newer line in the lower half
    pet_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (col_a),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            o_ent_win[r][0] = r_win[r][1];
            o_ent_win[r][1] = r_win[r][2];
        end
        o_ent_win[0][2] = top;
        o_ent_win[1][2] = mid;
        o_ent_win[2][2] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win <= o_ent_win;
        end
    end

    assign o_ent_valid = r_s1_valid && r_s1_emit;
    assign o_ent_tag   = r_s1_tag;

endmodule

/* design/pet_back.sv */
// Back end: Prewitt sums, gradient magnitude and threshold.
module pet_back import pet_pkg::*; #(
    parameter int PIXEL_BITS = P_PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ent_valid,
    output logic                            o_ent_ready,
    input  logic [2:0][2:0][PIXEL_BITS-1:0] i_ent_win,
    input  t_tag                            i_ent_tag,
    input  logic [THRESH_BITS-1:0]          i_edge_threshold,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output t_res                            o_res
);

    localparam int SB = PIXEL_BITS + 2;
    localparam int GB = SB + 1;

    logic          b1_adv;
    logic          b2_adv;

    logic          r_b1_valid;
    logic [SB-1:0] r_b1_right;
    logic [SB-1:0] r_b1_left;
    logic [SB-1:0] r_b1_bottom;
    logic [SB-1:0] r_b1_upper;
    t_tag          r_b1_tag;

    logic [SB-1:0] gx;
    logic [SB-1:0] gy;

    logic          r_b2_valid;
    logic [GB-1:0] r_b2_g;
    t_tag          r_b2_tag;

    assign b2_adv      = !r_b2_valid || i_res_ready;
    assign b1_adv      = !r_b1_valid || b2_adv;
    assign o_ent_ready = b1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            if (b1_adv) begin
                r_b1_valid <= i_ent_valid;
            end
            if (b2_adv) begin
                r_b2_valid <= r_b1_valid;
            end
        end
    end

    // Column and row sums of the window
    always_ff @(posedge i_clk) begin
        if (b1_adv) begin
            r_b1_right  <= SB'(i_ent_win[0][2]) + SB'(i_ent_win[1][2]) + SB'(i_ent_win[2][2]);
            r_b1_left   <= SB'(i_ent_win[0][0]) + SB'(i_ent_win[1][0]) + SB'(i_ent_win[2][0]);
            r_b1_bottom <= SB'(i_ent_win[2][0]) + SB'(i_ent_win[2][1]) + SB'(i_ent_win[2][2]);
            r_b1_upper  <= SB'(i_ent_win[0][0]) + SB'(i_ent_win[0][1]) + SB'(i_ent_win[0][2]);
            r_b1_tag    <= i_ent_tag;
        end
    end

    assign gx = (r_b1_right >= r_b1_left) ? r_b1_right - r_b1_left : r_b1_left - r_b1_right;
    assign gy = (r_b1_bottom >= r_b1_upper) ? r_b1_bottom - r_b1_upper
                                            : r_b1_upper - r_b1_bottom;

    always_ff @(posedge i_clk) begin
        if (b2_adv) begin
            r_b2_g   <= GB'(gx) + GB'(gy);
            r_b2_tag <= r_b1_tag;
        end
    end

    assign o_res_valid       = r_b2_valid;
    assign o_res.edge_value  = (32'(r_b2_g) <= 32'(i_edge_threshold)) ? EDGE_OFF : EDGE_ON;
    assign o_res.center_row  = r_b2_tag.center_row;
    assign o_res.center_col  = r_b2_tag.center_col;
    assign o_res.last        = r_b2_tag.last;

endmodule

/* design/prewitt_edge_threshold.sv */
// Top level of the Prewitt edge threshold block: configuration registers and queues.
//
// Pixels enter in raster order, one request per clock when the result side keeps up,
// and each interior pixel yields one thresholded result on the result ports once it
// has passed the window stage, the middle queue, the sum and magnitude registers and
// the result queue, held back while the result side stalls; border pixels yield none.
// The rate is set by the single line-store RAM, read and written once per pixel.
// After reset the line stores are swept to zero, during which full stays high;
// register writes are taken as ever. A short queue between the window front end and
// the gradient back end, and another on the result side, let each side stall
// independently. Geometry and threshold may be written only while the block is idle.
module prewitt_edge_threshold import pet_pkg::*; #(
    parameter int MAX_WIDTH  = P_MAX_WIDTH,
    parameter int PIXEL_BITS = P_PIXEL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  t_req                     i_req,
    output logic                     empty,
    input  logic                     pop,
    output t_res                     o_res,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int WIN_BITS = 9 * PIXEL_BITS;
    localparam int MID_BITS = WIN_BITS + $bits(t_tag);
    localparam int RES_BITS = $bits(t_res);

    logic [WIDTH_REG_BITS-1:0]       r_image_width;
    logic [HEIGHT_REG_BITS-1:0]      r_image_height;
    logic [THRESH_BITS-1:0]          r_edge_threshold;

    logic                            ent_valid;
    logic                            ent_ready;
    logic [2:0][2:0][PIXEL_BITS-1:0] ent_win;
    t_tag                            ent_tag;

    logic                            q_valid;
    logic                            q_ready;
    logic [MID_BITS-1:0]             q_data;
    logic [2:0][2:0][PIXEL_BITS-1:0] q_win;
    t_tag                            q_tag;

    logic                            res_valid;
    logic                            res_ready;
    t_res                            res;
    logic                            out_valid;
    logic [RES_BITS-1:0]             out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= RST_IMAGE_WIDTH;
            r_image_height   <= RST_IMAGE_HEIGHT;
            r_edge_threshold <= RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data[WIDTH_REG_BITS-1:0];
                REG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data[HEIGHT_REG_BITS-1:0];
                REG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    pet_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_req          (i_req),
        .o_full         (full),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_ent_valid    (ent_valid),
        .i_ent_ready    (ent_ready),
        .o_ent_win      (ent_win),
        .o_ent_tag      (ent_tag)
    );

    pet_fifo #(
        .WIDTH (MID_BITS),
        .DEPTH (MID_QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (ent_valid),
        .o_in_ready  (ent_ready),
        .i_in_data   ({ent_win, ent_tag}),
        .o_out_valid (q_valid),
        .i_out_ready (q_ready),
        .o_out_data  (q_data)
    );

    assign {q_win, q_tag} = q_data;

    pet_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ent_valid      (q_valid),
        .o_ent_ready      (q_ready),
        .i_ent_win        (q_win),
        .i_ent_tag        (q_tag),
        .i_edge_threshold (r_edge_threshold),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res)
    );

    pet_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (res_valid),
        .o_in_ready  (res_ready),
        .i_in_data   (res),
        .o_out_valid (out_valid),
        .i_out_ready (pop),
        .o_out_data  (out_data)
    );

    assign empty = !out_valid;
    assign o_res = out_data;

endmodule
